/* src/dre_pkg.sv */
// shared types and constants for the dns response ipv4 extractor
// no dependencies; used by the parser, the top level, the checker and the testbench
package dre_pkg;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_NAME    = 4'd1,
    PH_LABEL   = 4'd2,
    PH_PTR     = 4'd3,
    PH_QFIX    = 4'd4,
    PH_AFIX    = 4'd5,
    PH_ADATA   = 4'd6,
    PH_ASKIP   = 4'd7,
    PH_ERR_ID  = 4'd8,
    PH_ERR_SRV = 4'd9,
    PH_NOREC   = 4'd10,
    PH_DONE    = 4'd11
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ID     = 3'd1,
    ST_SERVER = 3'd2,
    ST_NOREC  = 3'd3,
    ST_TRUNC  = 3'd4
  } status_e;

  localparam logic [3:0]  HeaderLen    = 4'd12;
  localparam logic [3:0]  QFixLen      = 4'd4;
  localparam logic [3:0]  AFixLen      = 4'd10;
  localparam logic [3:0]  AFixLenStart = 4'd8;
  localparam logic [3:0]  AddrLen      = 4'd4;
  localparam logic [7:0]  PtrMask      = 8'hc0;
  localparam logic [31:0] TypeAClassIn = 32'h0001_0001;
  localparam logic [15:0] AddrDataLen  = 16'd4;

  typedef struct packed {
    logic        found;
    logic [31:0] ipv4_address;
    logic [2:0]  status;
  } dre_result_t;

endpackage

/* src/dre_if.sv */
// handshake channels of the extractor: input bytes, results and configuration
// depends on nothing; all three use valid/ready with a source and a sink modport
interface dre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output data_byte, output end_of_datagram, input ready);
  modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface dre_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] ipv4_address;
  logic [2:0]  status;

  modport source (output valid, output found, output ipv4_address, output status,
                  input ready);
  modport sink   (input valid, input found, input ipv4_address, input status,
                  output ready);
endinterface

interface dre_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] expected_id;

  modport source (output valid, output expected_id, input ready);
  modport sink   (input valid, input expected_id, output ready);
endinterface

/* src/dns_response_ipv4_extractor.sv */
// channel  | dir | payload                               | accepted when
// in_i     | in  | data_byte[7:0], end_of_datagram       | valid && ready
// out_o    | out | found, ipv4_address[31:0], status[2:0] | valid && ready
// cfg_i    | in  | expected_id[15:0]                     | valid && ready (ready always high)
//
// one byte per cycle unless a stalled result holds a byte back; each accepted byte is registered
// in the input register and feeds the parser, whose result goes to the output register
// a stalled result holds back only a byte that would give another result
// reset clears expected_id and all parse state; the block then waits for a header
// top level: input register, parser and result register; depends on dre_pkg,
// dre_if and dre_parser
module dns_response_ipv4_extractor (
  input  logic  clk_i,
  input  logic  rst_ni,
  dre_in_if.sink    in_i,
  dre_out_if.source out_o,
  dre_cfg_if.sink   cfg_i
);
  import dre_pkg::*;

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        in_eod_q;
  logic [15:0] exp_id_q;
  logic        out_vld_q;
  dre_result_t out_res_q;
  dre_result_t result;
  logic        advance;
  logic        emit;
  logic        out_free;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= 16'd0;
    end else if (cfg_i.valid) begin
      exp_id_q <= cfg_i.expected_id;
    end
  end

  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_eod_q  <= in_i.end_of_datagram;
    end
  end

  assign out_free = !out_vld_q || out_o.ready;

  dre_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (in_vld_q),
    .data_byte_i   (in_byte_q),
    .eod_i         (in_eod_q),
    .expected_id_i (exp_id_q),
    .out_free_i    (out_free),
    .advance_o     (advance),
    .emit_o        (emit),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_res_q <= result;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.found        = out_res_q.found;
  assign out_o.ipv4_address = out_res_q.ipv4_address;
  assign out_o.status       = out_res_q.status;

endmodule

/* src/dre_parser.sv */
// datagram walker: parse state registers and the per-byte next-state logic
// depends on dre_pkg
module dre_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 eod_i,
  input  logic [15:0]          expected_id_i,
  input  logic                 out_free_i,
  output logic                 advance_o,
  output logic                 emit_o,
  output dre_pkg::dre_result_t result_o
);
  import dre_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  fo_q, fo_d;
  logic [15:0] q_left_q, q_left_d;
  logic [15:0] a_left_q, a_left_d;
  logic [15:0] skip_q, skip_d;
  logic [31:0] rtc_q, rtc_d;
  logic [15:0] dlen_q, dlen_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] hw_q, hw_d;
  logic        given_q, given_d;
  logic [3:0]  fo_inc;
  logic [7:0]  b;

  assign b      = data_byte_i;
  assign fo_inc = fo_q + 4'd1;

  always_comb begin
    phase_d  = phase_q;
    fo_d     = fo_q;
    q_left_d = q_left_q;
    a_left_d = a_left_q;
    skip_d   = skip_q;
    rtc_d    = rtc_q;
    dlen_d   = dlen_q;
    addr_d   = addr_q;
    hw_d     = hw_q;
    given_d  = given_q;
    emit_o   = 1'b0;
    result_o = '{found: 1'b0, ipv4_address: 32'd0, status: ST_OK};

    case (phase_q)
      PH_HEADER: begin
        case (fo_q)
          4'd0: hw_d = {8'd0, b};
          4'd1: hw_d = ({hw_q[7:0], b} != expected_id_i) ? 16'd1 : 16'd0;
          4'd3: if (b[3:0] != 4'd0) hw_d = hw_q | 16'd2;
          4'd4: q_left_d = {b, 8'd0};
          4'd5: q_left_d = q_left_q | {8'd0, b};
          4'd6: a_left_d = {b, 8'd0};
          4'd7: a_left_d = a_left_q | {8'd0, b};
          default: ;
        endcase
        fo_d = fo_inc;
        if (fo_inc >= HeaderLen) begin
          fo_d = 4'd0;
          if (hw_d[0])      phase_d = PH_ERR_ID;
          else if (hw_d[1]) phase_d = PH_ERR_SRV;
          else              phase_d = (q_left_d != 16'd0 || a_left_d != 16'd0) ?
                                      PH_NAME : PH_NOREC;
        end
      end
      PH_NAME, PH_PTR: begin
        if (phase_q == PH_PTR || b == 8'd0) begin
          // end of name
          fo_d = 4'd0;
          if (q_left_q != 16'd0) begin
            phase_d = PH_QFIX;
          end else begin
            phase_d = PH_AFIX;
            rtc_d   = 32'd0;
            dlen_d  = 16'd0;
          end
        end else if ((b & PtrMask) == PtrMask) begin
          phase_d = PH_PTR;
        end else begin
          skip_d  = {8'd0, b};
          phase_d = PH_LABEL;
        end
      end
      PH_LABEL: begin
        skip_d = skip_q - 16'd1;
        if (skip_d == 16'd0) phase_d = PH_NAME;
      end
      PH_QFIX: begin
        fo_d = fo_inc;
        if (fo_inc >= QFixLen) begin
          fo_d     = 4'd0;
          q_left_d = q_left_q - 16'd1;
          phase_d  = (q_left_d != 16'd0 || a_left_q != 16'd0) ? PH_NAME : PH_NOREC;
        end
      end
      PH_AFIX: begin
        if (fo_q < 4'd4)               rtc_d  = {rtc_q[23:0], b};
        else if (fo_q >= AFixLenStart) dlen_d = {dlen_q[7:0], b};
        fo_d = fo_inc;
        if (fo_inc >= AFixLen) begin
          fo_d = 4'd0;
          if (rtc_d == TypeAClassIn && dlen_d == AddrDataLen) begin
            addr_d  = 32'd0;
            phase_d = PH_ADATA;
          end else if (dlen_d == 16'd0) begin
            a_left_d = a_left_q - 16'd1;
            phase_d  = (a_left_d != 16'd0) ? PH_NAME : PH_NOREC;
          end else begin
            skip_d  = dlen_d;
            phase_d = PH_ASKIP;
          end
        end
      end
      PH_ADATA: begin
        addr_d = {addr_q[23:0], b};
        fo_d   = fo_inc;
        if (fo_inc >= AddrLen) begin
          fo_d     = 4'd0;
          emit_o   = 1'b1;
          result_o = '{found: 1'b1, ipv4_address: addr_d, status: ST_OK};
          given_d  = 1'b1;
          phase_d  = PH_DONE;
        end
      end
      PH_ASKIP: begin
        skip_d = skip_q - 16'd1;
        if (skip_d == 16'd0) begin
          a_left_d = a_left_q - 16'd1;
          phase_d  = (a_left_d != 16'd0) ? PH_NAME : PH_NOREC;
        end
      end
      default: ;
    endcase

    if (eod_i) begin
      if (!given_d) begin
        emit_o = 1'b1;
        case (phase_d)
          PH_ERR_ID:  result_o.status = ST_ID;
          PH_ERR_SRV: result_o.status = ST_SERVER;
          PH_NOREC:   result_o.status = ST_NOREC;
          default:    result_o.status = ST_TRUNC;
        endcase
      end
      // back to the reset state for the next datagram
      phase_d  = PH_HEADER;
      fo_d     = 4'd0;
      q_left_d = 16'd0;
      a_left_d = 16'd0;
      skip_d   = 16'd0;
      rtc_d    = 32'd0;
      dlen_d   = 16'd0;
      addr_d   = 32'd0;
      hw_d     = 16'd0;
      given_d  = 1'b0;
    end
  end

  // an item that gives no result moves on even while the result register is full
  assign advance_o = item_valid_i && (!emit_o || out_free_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      fo_q     <= 4'd0;
      q_left_q <= 16'd0;
      a_left_q <= 16'd0;
      skip_q   <= 16'd0;
      rtc_q    <= 32'd0;
      dlen_q   <= 16'd0;
      addr_q   <= 32'd0;
      hw_q     <= 16'd0;
      given_q  <= 1'b0;
    end else if (advance_o) begin
      phase_q  <= phase_d;
      fo_q     <= fo_d;
      q_left_q <= q_left_d;
      a_left_q <= a_left_d;
      skip_q   <= skip_d;
      rtc_q    <= rtc_d;
      dlen_q   <= dlen_d;
      addr_q   <= addr_d;
      hw_q     <= hw_d;
      given_q  <= given_d;
    end
  end

endmodule

/* src/dre_checker.sv */
// port-level checks on the extractor's result channel, bound to the top level
// depends on dre_pkg and on the top level's interface ports
module dre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [31:0] out_addr,
  input logic [2:0]  out_status
);
  import dre_pkg::*;

  // a found address always carries the ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found result without ok status");

  // an error result never carries an address
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_found |-> out_addr == 32'd0)
    else $error("error result with nonzero address");

  a_miss_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_found |-> out_status != ST_OK)
    else $error("error result with ok status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_addr)
                                && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind dns_response_ipv4_extractor dre_checker u_dre_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_found  (out_o.found),
  .out_addr   (out_o.ipv4_address),
  .out_status (out_o.status)
);

/* verif/tb.sv */
// testbench for the dns response ipv4 extractor: byte stream in, one result per datagram out
// builds response datagrams, predicts each result with its own parser model and checks it
// depends on dre_pkg, dre_if and dns_response_ipv4_extractor
`timescale 1ns / 100ps

module tb;
  import dre_pkg::*;

  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 4;
  localparam int RandomBytes = 150;
  localparam int RandomResults = 4;

  localparam logic [15:0] TypeA      = 16'h0001;
  localparam logic [15:0] TypeCname  = 16'h0005;
  localparam logic [15:0] TypeAaaa   = 16'h001c;
  localparam logic [15:0] ClassIn    = 16'h0001;
  localparam logic [15:0] ClassChaos = 16'h0003;

  localparam int RxFree = 0;
  localparam int RxCoin = 1;
  localparam int RxEveryFourth = 2;
  localparam int RxRareStall = 3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dre_in_if  in_if();
  dre_out_if out_if();
  dre_cfg_if cfg_if();

  dns_response_ipv4_extractor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // parser model state, one datagram at a time
  phase_e      phase_q;
  logic [3:0]  offset_q;
  logic [15:0] questions_q;
  logic [15:0] answers_q;
  logic [15:0] skip_q;
  logic [31:0] type_class_q;
  logic [15:0] rdlength_q;
  logic [31:0] addr_q;
  logic [15:0] hdr_flags_q;
  bit          result_sent_q;
  logic [15:0] id_q;

  dre_result_t pending_results[$];
  logic [7:0]  dg[$];
  int          fail_count = 0;
  int          results_seen = 0;
  int          bytes_sent = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  bit          rx_hold = 1'b0;

  function automatic void clear_walk();
    phase_q = PH_HEADER;
    offset_q = '0;
    questions_q = '0;
    answers_q = '0;
    skip_q = '0;
    type_class_q = '0;
    rdlength_q = '0;
    addr_q = '0;
    hdr_flags_q = '0;
    result_sent_q = 1'b0;
  endfunction

  function automatic void enter_section();
    if (questions_q != 16'd0 || answers_q != 16'd0) phase_q = PH_NAME;
    else phase_q = PH_NOREC;
  endfunction

  function automatic void name_finished();
    offset_q = '0;
    if (questions_q != 16'd0) begin
      phase_q = PH_QFIX;
    end else begin
      phase_q = PH_AFIX;
      type_class_q = '0;
      rdlength_q = '0;
    end
  endfunction

  function automatic void answer_finished();
    answers_q = answers_q - 16'd1;
    if (answers_q != 16'd0) phase_q = PH_NAME;
    else phase_q = PH_NOREC;
  endfunction

  // returns 1 when this byte completes a result
  function automatic bit parse_response_byte(input logic [7:0] b, input logic eod,
                                             output dre_result_t res);
    bit given;
    given = 1'b0;
    res = '0;
    case (phase_q)
      PH_HEADER: begin
        case (offset_q)
          4'd0: hdr_flags_q = {8'h00, b};
          4'd1: hdr_flags_q = ({hdr_flags_q[7:0], b} != id_q) ? 16'd1 : 16'd0;
          4'd3: if (b[3:0] != 4'h0) hdr_flags_q[1] = 1'b1;
          4'd4: questions_q = {b, 8'h00};
          4'd5: questions_q[7:0] = b;
          4'd6: answers_q = {b, 8'h00};
          4'd7: answers_q[7:0] = b;
          default: ;
        endcase
        offset_q = offset_q + 4'd1;
        if (offset_q >= HeaderLen) begin
          offset_q = '0;
          if (hdr_flags_q[0]) phase_q = PH_ERR_ID;
          else if (hdr_flags_q[1]) phase_q = PH_ERR_SRV;
          else enter_section();
        end
      end
      PH_NAME: begin
        if (b == 8'h00) name_finished();
        else if ((b & PtrMask) == PtrMask) phase_q = PH_PTR;
        else begin
          skip_q = {8'h00, b};
          phase_q = PH_LABEL;
        end
      end
      PH_PTR: name_finished();
      PH_LABEL: begin
        skip_q = skip_q - 16'd1;
        if (skip_q == 16'd0) phase_q = PH_NAME;
      end
      PH_QFIX: begin
        offset_q = offset_q + 4'd1;
        if (offset_q >= QFixLen) begin
          offset_q = '0;
          questions_q = questions_q - 16'd1;
          enter_section();
        end
      end
      PH_AFIX: begin
        if (offset_q < 4'd4) type_class_q = {type_class_q[23:0], b};
        else if (offset_q >= AFixLenStart) rdlength_q = {rdlength_q[7:0], b};
        offset_q = offset_q + 4'd1;
        if (offset_q >= AFixLen) begin
          offset_q = '0;
          if (type_class_q == TypeAClassIn && rdlength_q == AddrDataLen) begin
            addr_q = '0;
            phase_q = PH_ADATA;
          end else if (rdlength_q == 16'd0) begin
            answer_finished();
          end else begin
            skip_q = rdlength_q;
            phase_q = PH_ASKIP;
          end
        end
      end
      PH_ADATA: begin
        addr_q = {addr_q[23:0], b};
        offset_q = offset_q + 4'd1;
        if (offset_q >= AddrLen) begin
          offset_q = '0;
          res.found = 1'b1;
          res.ipv4_address = addr_q;
          res.status = ST_OK;
          given = 1'b1;
          result_sent_q = 1'b1;
          phase_q = PH_DONE;
        end
      end
      PH_ASKIP: begin
        skip_q = skip_q - 16'd1;
        if (skip_q == 16'd0) answer_finished();
      end
      default: ;
    endcase

    if (eod) begin
      if (!result_sent_q) begin
        res.found = 1'b0;
        res.ipv4_address = '0;
        case (phase_q)
          PH_ERR_ID:  res.status = ST_ID;
          PH_ERR_SRV: res.status = ST_SERVER;
          PH_NOREC:   res.status = ST_NOREC;
          default:    res.status = ST_TRUNC;
        endcase
        given = 1'b1;
      end
      clear_walk();
    end
    return given;
  endfunction

  // ---- checking and watchdog, sampled at the rising edge

  always @(posedge clk_i) begin
    dre_result_t want;
    dre_result_t oldest;
    bit in_acc;
    bit out_acc;
    bit cfg_acc;
    if (rst_ni) begin
      in_acc = in_if.valid && in_if.ready;
      out_acc = out_if.valid && out_if.ready;
      cfg_acc = cfg_if.valid && cfg_if.ready;
      if (in_acc) begin
        if (parse_response_byte(in_if.data_byte, in_if.end_of_datagram, want))
          pending_results.push_back(want);
      end
      if (out_acc) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: found %0d, ipv4_address %08h, status %0d",
                 out_if.found, out_if.ipv4_address, out_if.status);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_if.found !== oldest.found) begin
            $error("found: expected %0d, actual %0d", oldest.found, out_if.found);
            fail_count++;
          end
          if (out_if.ipv4_address !== oldest.ipv4_address) begin
            $error("ipv4_address: expected %08h, actual %08h",
                   oldest.ipv4_address, out_if.ipv4_address);
            fail_count++;
          end
          if (out_if.status !== oldest.status) begin
            $error("status: expected %0d, actual %0d", oldest.status, out_if.status);
            fail_count++;
          end
        end
      end
      if (in_acc || out_acc || cfg_acc) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---- result side: stall pattern picked anew for each random-length segment

  initial begin
    int mode;
    int seg;
    int tick;
    out_if.ready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(RxFree, RxRareStall);
      seg = $urandom_range(40, 250);
      repeat (seg) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          RxFree:        out_if.ready <= !rx_hold;
          RxCoin:        out_if.ready <= !rx_hold && ($urandom_range(0, 1) == 1);
          RxEveryFourth: out_if.ready <= !rx_hold && (tick % 4 == 0);
          default:       out_if.ready <= !rx_hold && ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---- datagram building

  function automatic void put_random(input int n);
    repeat (n) dg.push_back(8'($urandom));
  endfunction

  function automatic void put_header(input logic [15:0] id, input logic [3:0] rcode,
                                     input logic [15:0] qd, input logic [15:0] an);
    dg.push_back(id[15:8]);
    dg.push_back(id[7:0]);
    dg.push_back(8'($urandom));
    dg.push_back({4'($urandom), rcode});
    dg.push_back(qd[15:8]);
    dg.push_back(qd[7:0]);
    dg.push_back(an[15:8]);
    dg.push_back(an[7:0]);
    put_random(4);
  endfunction

  function automatic void put_name(input int labels, input bit ptr);
    int len;
    repeat (labels) begin
      len = $urandom_range(1, 8);
      dg.push_back(8'(len));
      put_random(len);
    end
    if (ptr) begin
      dg.push_back({2'b11, 6'($urandom)});
      dg.push_back(8'($urandom));
    end else begin
      dg.push_back(8'h00);
    end
  endfunction

  function automatic void put_question(input int labels, input bit ptr);
    put_name(labels, ptr);
    put_random(4);
  endfunction

  // type, class, ttl and rdlength; the record data follows separately
  function automatic void put_record_tail(input logic [15:0] rtype, input logic [15:0] rclass,
                                          input logic [15:0] rdlen);
    dg.push_back(rtype[15:8]);
    dg.push_back(rtype[7:0]);
    dg.push_back(rclass[15:8]);
    dg.push_back(rclass[7:0]);
    put_random(4);
    dg.push_back(rdlen[15:8]);
    dg.push_back(rdlen[7:0]);
  endfunction

  function automatic void put_answer(input logic [15:0] rtype, input logic [15:0] rclass,
                                     input logic [15:0] rdlen);
    put_name($urandom_range(0, 2), 1'($urandom_range(0, 1)));
    put_record_tail(rtype, rclass, rdlen);
    put_random(int'(rdlen));
  endfunction

  function automatic void put_good_response();
    int qd;
    int an;
    int owed;
    int r;
    qd = $urandom_range(0, 2);
    an = $urandom_range(0, 3);
    owed = an;
    r = $urandom_range(0, 9);
    if (r == 0) owed = an + 1;
    else if (r == 1 && an > 0) owed = an - 1;
    put_header(id_q, 4'h0, 16'(qd), 16'(owed));
    repeat (qd) put_question($urandom_range(0, 3), 1'($urandom_range(0, 1)));
    repeat (an) begin
      r = $urandom_range(0, 99);
      if (r < 35) put_answer(TypeA, ClassIn, 16'd4);
      else if (r < 50) put_answer(TypeA, ClassIn, 16'($urandom_range(0, 6)));
      else if (r < 65) put_answer(TypeAaaa, ClassIn, 16'd16);
      else if (r < 75) put_answer({8'($urandom), 8'h01}, {8'($urandom), 8'h01}, 16'd4);
      else put_answer(16'($urandom), 16'($urandom), 16'($urandom_range(0, 12)));
    end
    if ($urandom_range(0, 1) == 1) put_random($urandom_range(1, 10));
  endfunction

  // ---- driving, at the falling edge

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady) gap = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.end_of_datagram <= eod;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  // sends the first keep bytes of the built datagram (all when keep is out of range), the last one marked as the end
  task automatic send_datagram(input int keep);
    int n;
    n = (keep <= 0 || keep > dg.size()) ? dg.size() : keep;
    for (int i = 0; i < n; i++) send_byte(dg[i], i == n - 1);
    dg.delete();
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_id(input logic [15:0] id);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.expected_id <= id;
    do @(posedge clk_i); while (!cfg_if.ready);
    id_q = id;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // ---- tests

  task automatic test_header_checks();
    // id register still at its reset value
    put_header(16'h0000, 4'h0, 16'd1, 16'd1);
    put_question(1, 1'b0);
    dg.push_back(8'h00);
    put_record_tail(TypeA, ClassIn, 16'd4);
    dg.push_back(8'hff);
    dg.push_back(8'h00);
    dg.push_back(8'h80);
    dg.push_back(8'h7f);
    send_datagram(0);
    put_header(16'hffff, 4'h0, 16'd1, 16'd1);
    send_datagram(0);
    settle();
    write_id(16'hffff);
    put_header(16'hffff, 4'hf, 16'd0, 16'd0);
    put_random(3);
    send_datagram(0);
    // wrong id and a server error together: the id wins
    put_header(16'hff00, 4'h1, 16'd1, 16'd1);
    send_datagram(0);
    put_header(16'hffff, 4'h0, 16'd0, 16'd0);
    put_random(5);
    send_datagram(0);
    put_header(16'hffff, 4'h0, 16'd0, 16'd0);
    send_datagram(0);
  endtask

  task automatic test_name_walking();
    put_header(id_q, 4'h0, 16'd2, 16'd2);
    dg.push_back(8'hbf);
    put_random(191);
    dg.push_back(8'h40);
    put_random(64);
    dg.push_back(8'h00);
    put_random(4);
    dg.push_back(8'hff);
    dg.push_back(8'hff);
    put_random(4);
    // label then pointer, then a root name
    dg.push_back(8'h80);
    put_random(128);
    dg.push_back(8'hc0);
    dg.push_back(8'h0c);
    put_record_tail(TypeCname, ClassIn, 16'd2);
    put_random(2);
    dg.push_back(8'h00);
    put_record_tail(TypeA, ClassIn, 16'd4);
    put_random(4);
    send_datagram(0);
  endtask

  task automatic test_records();
    settle();
    write_id(16'($urandom));
    put_header(id_q, 4'h0, 16'd0, 16'd7);
    put_answer(TypeCname, ClassIn, 16'd3);
    put_answer(16'h0101, ClassIn, 16'd4);
    put_answer(TypeA, 16'h0101, 16'd4);
    put_answer(TypeA, ClassChaos, 16'd4);
    put_answer(TypeA, ClassIn, 16'd0);
    put_answer(TypeA, ClassIn, 16'd4);
    put_answer(TypeA, ClassIn, 16'd4);
    send_datagram(0);
    put_header(id_q, 4'h0, 16'd1, 16'd2);
    put_question(1, 1'b1);
    put_answer(TypeAaaa, ClassIn, 16'd16);
    put_answer(TypeA, ClassIn, 16'd5);
    put_random(7);
    send_datagram(0);
    put_header(id_q, 4'h0, 16'd0, 16'hffff);
    put_answer(TypeA, ClassIn, 16'd4);
    send_datagram(0);
    // record data length with a nonzero high byte
    steady = 1'b1;
    put_header(id_q, 4'h0, 16'd0, 16'd2);
    put_answer(TypeAaaa, ClassIn, 16'h0101);
    put_answer(TypeA, ClassIn, 16'd4);
    send_datagram(0);
    steady = 1'b0;
  endtask

  task automatic test_early_end();
    int n;
    settle();
    write_id(16'h0000);
    dg.push_back(8'hff);
    send_datagram(0);
    dg.push_back(8'h00);
    send_datagram(0);
    put_header(id_q, 4'h0, 16'd1, 16'd1);
    send_datagram(11);
    put_header(id_q, 4'h0, 16'hffff, 16'd0);
    put_question(1, 1'b0);
    put_question(0, 1'b1);
    send_datagram(0);
    put_header(id_q, 4'h0, 16'd1, 16'd1);
    put_question(2, 1'b0);
    put_answer(TypeA, ClassIn, 16'd4);
    send_datagram(14);
    put_header(id_q, 4'h0, 16'd1, 16'd1);
    put_question(1, 1'b0);
    put_answer(TypeA, ClassIn, 16'd4);
    n = dg.size();
    send_datagram(n - 6);
    put_header(id_q, 4'h0, 16'd1, 16'd1);
    put_question(1, 1'b1);
    put_answer(TypeA, ClassIn, 16'd4);
    n = dg.size();
    send_datagram(n - 1);
    // answers still owed when the datagram ends
    put_header(id_q, 4'h0, 16'd0, 16'd2);
    put_answer(TypeCname, ClassIn, 16'd3);
    send_datagram(0);
    put_header(id_q, 4'h0, 16'd0, 16'd1);
    put_answer(TypeA, ClassIn, 16'd4);
    send_datagram(0);
  endtask

  task automatic test_backpressure();
    settle();
    write_id(16'h8001);
    steady = 1'b1;
    fork
      begin
        rx_hold = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    // header-only server errors give a result every twelve bytes
    repeat (24) begin
      put_header(id_q, 4'h3, 16'd0, 16'd0);
      send_datagram(0);
    end
    steady = 1'b0;
    settle();
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    int start_results;
    int count;
    int r;
    start_bytes = bytes_sent;
    start_results = results_seen;
    count = 0;
    while (bytes_sent - start_bytes < RandomBytes ||
           results_seen - start_results < RandomResults) begin
      if (count % 12 == 0) begin
        settle();
        r = $urandom_range(0, 3);
        if (r == 0) write_id(16'h0000);
        else if (r == 1) write_id(16'hffff);
        else write_id(16'($urandom));
      end
      count++;
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        put_good_response();
        send_datagram(0);
      end else if (r < 85) begin
        put_good_response();
        send_datagram($urandom_range(1, dg.size()));
      end else if (r < 95) begin
        if ($urandom_range(0, 1) == 1)
          put_header(id_q ^ (16'd1 << $urandom_range(0, 15)), 4'($urandom),
                     16'd1, 16'd1);
        else
          put_header(id_q, 4'($urandom_range(1, 15)), 16'd1, 16'd1);
        put_random($urandom_range(0, 20));
        send_datagram(0);
      end else begin
        put_random($urandom_range(1, 30));
        send_datagram(0);
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.end_of_datagram = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.expected_id = 16'h0000;
    id_q = 16'h0000;
    clear_walk();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_header_checks();
    test_name_walking();
    test_records();
    test_early_end();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* dns_response_ipv4_extractor.f */
src/dre_pkg.sv
src/dre_if.sv
src/dre_parser.sv
src/dns_response_ipv4_extractor.sv
src/dre_checker.sv
verif/tb.sv
